FILE: hdl/ips_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ips_pkg
// Shared types, register map and status codes of the irrigation pulse
// scheduler.
// -----------------------------------------------------------------------------
package ips_pkg;

    // Default widths of the internal time and daily count registers.
    localparam int TIME_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 16;

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes, taken from byte address bits [4:2].
    localparam logic [2:0] REG_TRIGGER  = 3'd0;
    localparam logic [2:0] REG_DELAY    = 3'd1;
    localparam logic [2:0] REG_PULSE    = 3'd2;
    localparam logic [2:0] REG_SETTLE   = 3'd3;
    localparam logic [2:0] REG_MAX_DAY  = 3'd4;

    // Register reset values.
    localparam logic [9:0]  TRIGGER_RST = 10'd300;
    localparam logic [15:0] DELAY_RST   = 16'd60;
    localparam logic [15:0] PULSE_RST   = 16'd5;
    localparam logic [19:0] SETTLE_RST  = 20'd1800;
    localparam logic [15:0] MAX_DAY_RST = 16'd4;

    // Operation codes.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    // Status codes reported with each result beat.
    localparam logic [3:0] ST_NONE        = 4'd0;
    localparam logic [3:0] ST_SCHEDULED   = 4'd1;
    localparam logic [3:0] ST_LOW_RES     = 4'd2;
    localparam logic [3:0] ST_NOT_DRY     = 4'd3;
    localparam logic [3:0] ST_SETTLING    = 4'd4;
    localparam logic [3:0] ST_CAP         = 4'd5;
    localparam logic [3:0] ST_BUSY        = 4'd6;
    localparam logic [3:0] ST_STARTED     = 4'd7;
    localparam logic [3:0] ST_ABORTED_CAP = 4'd8;
    localparam logic [3:0] ST_REFUSED     = 4'd9;

    // Input beat.
    typedef struct packed {
        logic        op;
        logic [31:0] now_sec;
        logic [9:0]  soil_tenths;
        logic        reservoir_low;
        logic        day_valid;
        logic [8:0]  day_index;
        logic        override_active;
        logic        override_on;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic        pump_drive;
        logic        pulse_pending;
        logic [15:0] pulses_done_today;
        logic [3:0]  status;
    } out_beat_t;

    // Configuration register set handed to the scheduling core.
    typedef struct packed {
        logic [9:0]  trigger_tenths;
        logic [15:0] schedule_delay_sec;
        logic [15:0] pulse_sec;
        logic [19:0] settle_sec;
        logic [15:0] max_pulses_per_day;
    } cfg_t;

endpackage

FILE: hdl/irrigation_pulse_scheduler_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// irrigation_pulse_scheduler_unit
// Pump pulse scheduler driven by tick and soil measurement beats.
// -----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in        sink       in_valid / in_stall  ips_pkg::in_beat_t
//  out       source     out_valid/out_stall  ips_pkg::out_beat_t
//  config    slave      psel/penable/pready  32-bit registers at 4*index
//
//  One beat per cycle is sustained while the result is not stalled; each beat
//  passes from acceptance through the input register and the result register.
//  The throughput is set by the single evaluation pass between the two.
//  Reset clears the pump, the schedule, the daily count and the day tracking.
//  A stalled result holds the result register; the input register keeps
//  accepting while it is empty, so one further beat is taken during a stall.
// -----------------------------------------------------------------------------
module irrigation_pulse_scheduler_unit #(
    parameter int TIME_BITS  = ips_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = ips_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  ips_pkg::in_beat_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output ips_pkg::out_beat_t          out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ips_pkg::ADDR_W-1:0]  paddr,
    input  logic [ips_pkg::DATA_W-1:0]  pwdata,
    output logic [ips_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    ips_pkg::cfg_t      cfg;
    ips_pkg::in_beat_t  item_reg;
    logic               item_valid_reg;
    ips_pkg::out_beat_t result;
    ips_pkg::out_beat_t out_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               fire;
    logic               in_take;

    // Register file.
    ips_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Evaluation of the item held in the input register.
    ips_sched_core #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Pipeline control: the result register frees when empty or taken.
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = item_valid_reg && advance;
    assign in_stall  = item_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= item_valid_reg;
            if (in_take)
                item_valid_reg <= 1'b1;
            else if (fire)
                item_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= in_data;
        if (fire)
            out_reg <= result;
    end

    // A started pulse always drives the pump.
    a_started_drives: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ips_pkg::ST_STARTED) |-> out_data.pump_drive)
        else $error("started pulse without pump drive");

    // A schedule is only made while the pump is idle, and a measurement never
    // switches it on.
    a_sched_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ips_pkg::ST_SCHEDULED) |-> !out_data.pump_drive)
        else $error("scheduled pulse with pump running");

    // The input side only stalls when both pipeline registers are full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    // An item leaving the input register appears as a result next cycle.
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("evaluated item produced no result");

endmodule

FILE: hdl/ips_cfg_regs.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ips_cfg_regs
// APB-style register file holding the scheduler thresholds and timings.
// -----------------------------------------------------------------------------
module ips_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ips_pkg::ADDR_W-1:0]  paddr,
    input  logic [ips_pkg::DATA_W-1:0]  pwdata,
    output logic [ips_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ips_pkg::cfg_t               cfg
);

    ips_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_tenths     <= ips_pkg::TRIGGER_RST;
            cfg_reg.schedule_delay_sec <= ips_pkg::DELAY_RST;
            cfg_reg.pulse_sec          <= ips_pkg::PULSE_RST;
            cfg_reg.settle_sec         <= ips_pkg::SETTLE_RST;
            cfg_reg.max_pulses_per_day <= ips_pkg::MAX_DAY_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ips_pkg::REG_TRIGGER: cfg_reg.trigger_tenths     <= pwdata[9:0];
                ips_pkg::REG_DELAY:   cfg_reg.schedule_delay_sec <= pwdata[15:0];
                ips_pkg::REG_PULSE:   cfg_reg.pulse_sec          <= pwdata[15:0];
                ips_pkg::REG_SETTLE:  cfg_reg.settle_sec         <= pwdata[19:0];
                ips_pkg::REG_MAX_DAY: cfg_reg.max_pulses_per_day <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    // Read-back mux; addresses beyond the map read as zero.
    always_comb
    begin
        unique case (reg_idx)
            ips_pkg::REG_TRIGGER: prdata = 32'(cfg_reg.trigger_tenths);
            ips_pkg::REG_DELAY:   prdata = 32'(cfg_reg.schedule_delay_sec);
            ips_pkg::REG_PULSE:   prdata = 32'(cfg_reg.pulse_sec);
            ips_pkg::REG_SETTLE:  prdata = 32'(cfg_reg.settle_sec);
            ips_pkg::REG_MAX_DAY: prdata = 32'(cfg_reg.max_pulses_per_day);
            default:              prdata = '0;
        endcase
    end

endmodule

FILE: hdl/ips_sched_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ips_sched_core
// Scheduler state and the single-pass evaluation of one tick or measurement.
// -----------------------------------------------------------------------------
module ips_sched_core #(
    parameter int TIME_BITS  = ips_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = ips_pkg::COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  ips_pkg::in_beat_t  item,
    input  ips_pkg::cfg_t      cfg,
    output ips_pkg::out_beat_t result
);

    // Working widths wide enough for the fixed-width fields and the state.
    localparam int XW  = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int CXW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic                  pump_reg, pump_next;
    logic [TIME_BITS-1:0]  start_at_reg, start_at_next;
    logic [TIME_BITS-1:0]  run_until_reg, run_until_next;
    logic [TIME_BITS-1:0]  last_start_reg, last_start_next;
    logic [COUNT_BITS-1:0] day_count_reg, day_count_next;
    logic [8:0]            seen_day_reg, seen_day_next;
    logic                  seen_known_reg, seen_known_next;

    logic [XW-1:0]         now_wide, delay_wide, pulse_wide, settle_wide, since_wide;
    logic [TIME_BITS-1:0]  now;
    logic [TIME_BITS-1:0]  since_start;
    logic [COUNT_BITS-1:0] count_day;
    logic                  cap_hit;
    logic                  day_change;
    logic [CXW-1:0]        count_out;
    logic [3:0]            status;

    assign now_wide    = XW'(item.now_sec);
    assign now         = now_wide[TIME_BITS-1:0];
    assign delay_wide  = XW'(cfg.schedule_delay_sec);
    assign pulse_wide  = XW'(cfg.pulse_sec);
    assign settle_wide = XW'(cfg.settle_sec);
    assign since_start = now - last_start_reg;
    assign since_wide  = XW'(since_start);

    // Day roll-over only matters for ticks; measurements see the stored count.
    assign day_change = (item.op == ips_pkg::OP_TICK) && !item.override_active &&
                        item.day_valid &&
                        (!seen_known_reg || (item.day_index != seen_day_reg));
    assign count_day  = day_change ? '0 : day_count_reg;
    assign cap_hit    = CXW'(count_day) >= CXW'(cfg.max_pulses_per_day);

    // Next state and status for the item in the evaluation register.
    always_comb
    begin
        pump_next       = pump_reg;
        start_at_next   = start_at_reg;
        run_until_next  = run_until_reg;
        last_start_next = last_start_reg;
        day_count_next  = count_day;
        seen_day_next   = seen_day_reg;
        seen_known_next = seen_known_reg;
        status          = ips_pkg::ST_NONE;

        if (item.op == ips_pkg::OP_MEASURE)
        begin
            if (item.reservoir_low)
                status = ips_pkg::ST_LOW_RES;
            else if (item.soil_tenths > cfg.trigger_tenths)
                status = ips_pkg::ST_NOT_DRY;
            else if ((last_start_reg != '0) && (since_wide < settle_wide))
                status = ips_pkg::ST_SETTLING;
            else if (cap_hit)
                status = ips_pkg::ST_CAP;
            else if ((start_at_reg != '0) || pump_reg)
                status = ips_pkg::ST_BUSY;
            else
            begin
                start_at_next = now + delay_wide[TIME_BITS-1:0];
                status        = ips_pkg::ST_SCHEDULED;
            end
        end
        else if (item.override_active)
        begin
            // Manual override: an "on" request is refused on a low reservoir.
            pump_next = item.override_on && !item.reservoir_low;
            if (item.override_on && item.reservoir_low)
                status = ips_pkg::ST_REFUSED;
        end
        else
        begin
            if (day_change)
            begin
                seen_day_next   = item.day_index;
                seen_known_next = 1'b1;
            end
            if (pump_reg && (now >= run_until_reg))
                pump_next = 1'b0;
            if ((start_at_reg != '0) && (now >= start_at_reg))
            begin
                if (cap_hit)
                    status = ips_pkg::ST_ABORTED_CAP;
                else
                begin
                    pump_next       = 1'b1;
                    run_until_next  = now + pulse_wide[TIME_BITS-1:0];
                    last_start_next = now;
                    if (count_day != '1)
                        day_count_next = count_day + COUNT_BITS'(1);
                    status = ips_pkg::ST_STARTED;
                end
                start_at_next = '0;
            end
        end
    end

    assign count_out                = CXW'(day_count_next);
    assign result.pump_drive        = pump_next;
    assign result.pulse_pending     = (start_at_next != '0);
    assign result.pulses_done_today = count_out[15:0];
    assign result.status            = status;

    // State advances once for every item that leaves the evaluation register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pump_reg       <= 1'b0;
            start_at_reg   <= '0;
            run_until_reg  <= '0;
            last_start_reg <= '0;
            day_count_reg  <= '0;
            seen_day_reg   <= '0;
            seen_known_reg <= 1'b0;
        end
        else if (fire)
        begin
            pump_reg       <= pump_next;
            start_at_reg   <= start_at_next;
            run_until_reg  <= run_until_next;
            last_start_reg <= last_start_next;
            day_count_reg  <= day_count_next;
            seen_day_reg   <= seen_day_next;
            seen_known_reg <= seen_known_next;
        end
    end

endmodule
